// ===== src/blr_pkg.sv =====
// shared types and constants for the line rasterizer
`default_nettype none

package blr_pkg;

  // coordinate and derived widths
  localparam int COORD_BITS = 12;
  localparam int SPAN_BITS  = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 4;
  localparam int COLOR_BITS = 24;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SPAN_BITS-1:0]  span_t;
  typedef logic signed [ERR_BITS-1:0]   err_t;
  typedef logic [COLOR_BITS-1:0]        color_t;

  // request opcodes
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  // octant codes
  typedef enum logic [1:0] {
    OCT_SHALLOW_UP   = 2'd0,
    OCT_SHALLOW_DOWN = 2'd1,
    OCT_STEEP_UP     = 2'd2,
    OCT_STEEP_DOWN   = 2'd3
  } oct_t;

  // input request
  typedef struct packed {
    cmd_t   cmd;
    coord_t start_x;
    coord_t start_y;
    coord_t finish_x;
    coord_t finish_y;
  } req_t;

  // output pixel
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last_pixel;
  } pixel_t;

endpackage

`default_nettype wire

// ===== src/blr_step.sv =====
// line state registers and the per-request setup and step logic
`default_nettype none

module blr_step
  import blr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   take,
  input  wire req_t   req,
  input  wire color_t color,
  output logic        res_valid,
  output pixel_t      res
);

  // line state
  logic   line_active;
  logic   line_active_next;
  coord_t pos_x, pos_x_next;
  coord_t pos_y, pos_y_next;
  coord_t target_x, target_x_next;
  coord_t target_y, target_y_next;
  err_t   error_term, error_term_next;
  err_t   step_plain, step_plain_next;
  err_t   step_diag, step_diag_next;
  oct_t   octant_sel, octant_sel_next;

  // setup terms
  coord_t x0, y0, x1, y1;
  span_t  dx, dy, ady;
  err_t   dxe, dye;
  logic   shallow, rising;

  // step terms
  logic   more, diag;

  // endpoint ordering and slope classification
  always_comb begin
    if ($signed(req.start_x) > $signed(req.finish_x)) begin
      x0 = req.finish_x;
      y0 = req.finish_y;
      x1 = req.start_x;
      y1 = req.start_y;
    end else begin
      x0 = req.start_x;
      y0 = req.start_y;
      x1 = req.finish_x;
      y1 = req.finish_y;
    end
    dx      = span_t'(x1) - span_t'(x0);
    dy      = span_t'(y1) - span_t'(y0);
    ady     = dy[SPAN_BITS-1] ? -dy : dy;
    shallow = dx >= ady;
    rising  = dy > span_t'(0);
    dxe     = err_t'(dx);
    dye     = err_t'(dy);
  end

  // continue test and diagonal decision
  always_comb begin
    unique case (octant_sel)
      OCT_SHALLOW_UP: begin
        more = pos_x < target_x;
        diag = error_term > err_t'(0);
      end
      OCT_SHALLOW_DOWN: begin
        more = pos_x < target_x;
        diag = error_term < err_t'(0);
      end
      OCT_STEEP_UP: begin
        more = pos_y < target_y;
        diag = error_term < err_t'(0);
      end
      OCT_STEEP_DOWN: begin
        more = pos_y > target_y;
        diag = error_term > err_t'(0);
      end
      default: begin
        more = 1'b0;
        diag = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    line_active_next = line_active;
    pos_x_next       = pos_x;
    pos_y_next       = pos_y;
    target_x_next    = target_x;
    target_y_next    = target_y;
    error_term_next  = error_term;
    step_plain_next  = step_plain;
    step_diag_next   = step_diag;
    octant_sel_next  = octant_sel;
    if (take && req.cmd == CMD_LOAD) begin
      line_active_next = 1'b1;
      pos_x_next       = x0;
      pos_y_next       = y0;
      target_x_next    = x1;
      target_y_next    = y1;
      priority if (shallow && rising) begin
        octant_sel_next = OCT_SHALLOW_UP;
        error_term_next = (dye <<< 1) - dxe;
        step_plain_next = dye <<< 1;
        step_diag_next  = (dye <<< 1) - (dxe <<< 1);
      end else if (shallow) begin
        octant_sel_next = OCT_SHALLOW_DOWN;
        error_term_next = (dye <<< 1) + dxe;
        step_plain_next = dye <<< 1;
        step_diag_next  = (dye <<< 1) + (dxe <<< 1);
      end else if (rising) begin
        octant_sel_next = OCT_STEEP_UP;
        error_term_next = dye - (dxe <<< 1);
        step_plain_next = -(dxe <<< 1);
        step_diag_next  = (dye <<< 1) - (dxe <<< 1);
      end else begin
        octant_sel_next = OCT_STEEP_DOWN;
        error_term_next = dye + (dxe <<< 1);
        step_plain_next = dxe <<< 1;
        step_diag_next  = (dye <<< 1) + (dxe <<< 1);
      end
    end else if (take && line_active) begin
      if (!more) begin
        line_active_next = 1'b0;
      end else begin
        error_term_next = error_term + (diag ? step_diag : step_plain);
        unique case (octant_sel)
          OCT_SHALLOW_UP: begin
            pos_x_next = pos_x + coord_t'(1);
            if (diag) pos_y_next = pos_y + coord_t'(1);
          end
          OCT_SHALLOW_DOWN: begin
            pos_x_next = pos_x + coord_t'(1);
            if (diag) pos_y_next = pos_y - coord_t'(1);
          end
          OCT_STEEP_UP: begin
            pos_y_next = pos_y + coord_t'(1);
            if (diag) pos_x_next = pos_x + coord_t'(1);
          end
          OCT_STEEP_DOWN: begin
            pos_y_next = pos_y - coord_t'(1);
            if (diag) pos_x_next = pos_x + coord_t'(1);
          end
          default: begin
            pos_x_next = pos_x;
          end
        endcase
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else begin
      line_active <= line_active_next;
    end
  end

  // line datapath registers
  always_ff @(posedge clk) begin
    pos_x      <= pos_x_next;
    pos_y      <= pos_y_next;
    target_x   <= target_x_next;
    target_y   <= target_y_next;
    error_term <= error_term_next;
    step_plain <= step_plain_next;
    step_diag  <= step_diag_next;
    octant_sel <= octant_sel_next;
  end

  // pixel for a step request on an active line
  always_comb begin
    res_valid       = take && req.cmd == CMD_STEP && line_active;
    res.pixel_x     = more ? pos_x : target_x;
    res.pixel_y     = more ? pos_y : target_y;
    res.pixel_color = color;
    res.last_pixel  = !more;
  end

endmodule

`default_nettype wire

// ===== src/blr_out_buf.sv =====
// two-entry output buffer: a circular FIFO with read and write pointers
`default_nettype none

module blr_out_buf
  import blr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire pixel_t push_data,
  output logic        full,
  output logic        pix_valid,
  input  wire logic   pix_stall,
  output pixel_t      pix
);

  pixel_t     entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       pop;

  // occupancy
  always_comb begin
    pop        = pix_valid && !pix_stall;
    count_next = count + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count_next;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  assign full      = count == 2'd2;
  assign pix_valid = count != 2'd0;
  assign pix       = entry[rd_ptr];

endmodule

`default_nettype wire

// ===== src/bresenham_line_rasterizer.sv =====
// top level of the stepped line rasterizer
//
// Usage: a request with cmd = load carries both endpoints and arms a line
// (any line in progress is dropped); it gives no pixel. Each request with
// cmd = step gives one pixel: the current position, or the far endpoint with
// last_pixel set, after which the line is idle. A step while idle gives no
// pixel. Requests and pixels move on valid/stall channels; a request is
// taken when req_valid is high and req_stall low.
// draw_color is written on the cfg channel (cfg_ready is always high) and is
// copied into each pixel when its step request is taken.
// A pixel is registered into the output buffer when its step request is taken.
// Throughput: one request per cycle while req_stall is low; setup and each
// step work on the line registers in the cycle the request is taken.
// A two-entry output buffer decouples the sides: req_stall rises only when
// both entries hold pixels that the receiver has not taken, so a receiver
// stall blocks requests only once both entries are full and never loses a pixel.
// Reset (synchronous): line idle, output buffer empty, draw_color zero.
`default_nettype none

module bresenham_line_rasterizer
  import blr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   req_valid,
  output logic        req_stall,
  input  wire req_t   req,
  output logic        pix_valid,
  input  wire logic   pix_stall,
  output pixel_t      pix,
  input  wire logic   cfg_valid,
  output logic        cfg_ready,
  input  wire color_t cfg_data
);

  color_t draw_color;
  logic   take;
  logic   res_valid;
  pixel_t res;
  logic   full;

  // colour register
  always_ff @(posedge clk) begin
    if (rst) begin
      draw_color <= '0;
    end else if (cfg_valid && cfg_ready) begin
      draw_color <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign take      = req_valid && !req_stall;
  assign req_stall = full;

  // line setup and stepping
  blr_step u_step (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .req       (req),
    .color     (draw_color),
    .res_valid (res_valid),
    .res       (res)
  );

  // pixel output buffer
  blr_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (full),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix)
  );

endmodule

`default_nettype wire

// ===== src/blr_checker.sv =====
// port-level checks for the line rasterizer and their bind
`default_nettype none

module blr_checker
  import blr_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst,
  input wire logic   req_valid,
  input wire logic   req_stall,
  input wire req_t   req,
  input wire logic   pix_valid,
  input wire logic   pix_stall,
  input wire pixel_t pix
);

  // buffer empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !pix_valid)
    else $error("pixel valid after reset");

  // requests are held back only while pixels are pending
  a_stall_needs_pixel: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> pix_valid)
    else $error("request stalled with no pixel pending");

  // a load into an empty block makes no pixel
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (!pix_valid && req_valid && !req_stall && req.cmd == CMD_LOAD) |=> !pix_valid)
    else $error("load request produced a pixel");

  // a stalled pixel holds
  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && pix_stall) |=> (pix_valid && $stable(pix)))
    else $error("stalled pixel changed");

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .pix_valid (pix_valid),
  .pix_stall (pix_stall),
  .pix       (pix)
);

`default_nettype wire
